// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL files; ccc_walk.sv includes them.
// Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define CCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define CCC_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define CCC_ASSERT(label, clk, rst_n, prop, msg)
`define CCC_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/core/ccc_pkg.sv =====
package ccc_pkg;

    // Field widths
    localparam int CMD_W = 2;
    localparam int VTX_W = 7;
    localparam int CNT_W = 7;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COUNT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    // Configuration port
    localparam int              CFG_ADDR_W       = 3;
    localparam int              CFG_DATA_W       = 32;
    localparam logic            REG_VERTEX_COUNT = 1'b0;
    localparam logic [VTX_W-1:0] VERTEX_COUNT_RST = 7'd64;

    // Finished count handed from the walker to the output stage
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
    } t_result;

endpackage

// ===== rtl/core/ccc_ram.sv =====
module ccc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ccc_cfg.sv =====
module ccc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ccc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ccc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ccc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [ccc_pkg::VTX_W-1:0]      o_vertex_count
);
    import ccc_pkg::*;

    logic [VTX_W-1:0] r_vertex_count;
    logic             wr_hit;

    // Word index is paddr[2]; only word 0 exists
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VERTEX_COUNT_RST;
        end else if (wr_hit) begin
            r_vertex_count <= pwdata[VTX_W-1:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_VERTEX_COUNT) begin
            prdata = {{(CFG_DATA_W-VTX_W){1'b0}}, r_vertex_count};
        end
    end

    assign pready         = 1'b1;
    assign o_vertex_count = r_vertex_count;

endmodule

// ===== rtl/core/ccc_walk.sv =====
`include "assert_macros.svh"

module ccc_walk #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [ccc_pkg::VTX_W-1:0] i_vertex_count,
    input  logic                      i_cmd_valid,
    input  logic [ccc_pkg::CMD_W-1:0] i_command,
    input  logic [ccc_pkg::VTX_W-1:0] i_vertex_a,
    input  logic [ccc_pkg::VTX_W-1:0] i_vertex_b,
    input  logic                      i_res_free,
    output logic                      o_busy,
    output ccc_pkg::t_result          o_result
);
    import ccc_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int VW = $clog2(MAX_VERTICES + 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ADD_A = 4'd2;
    localparam logic [3:0] S_ADD_B = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_ROW   = 4'd5;
    localparam logic [3:0] S_PUSH  = 4'd6;
    localparam logic [3:0] S_POP   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]              r_state, n_state;
    logic [AW-1:0]           r_clr_idx, n_clr_idx;
    logic [VW-1:0]           r_u, n_u;
    logic [CNT_W-1:0]        r_tally, n_tally;
    logic [AW:0]             r_sp, n_sp;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [MAX_VERTICES-1:0] r_cand, n_cand;
    logic [AW-1:0]           r_w, n_w;
    logic [AW-1:0]           r_row_a, n_row_a;
    logic [AW-1:0]           r_row_b, n_row_b;

    // Adjacency and stack memory ports
    logic                    adj_we;
    logic [AW-1:0]           adj_waddr, adj_raddr;
    logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
    logic                    stk_we;
    logic [AW-1:0]           stk_waddr, stk_raddr;
    logic [AW-1:0]           stk_wdata, stk_rdata;

    logic [31:0]             vc_ext, a_ext, b_ext, n_ext;
    logic [VW-1:0]           n_act;
    logic                    edge_ok;
    logic [MAX_VERTICES-1:0] act_mask;
    logic [MAX_VERTICES-1:0] row_new;

    ccc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    ccc_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // Effective vertex count, clamped to the store size
    assign vc_ext = 32'(i_vertex_count);
    assign n_act  = (vc_ext > 32'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : VW'(vc_ext);
    assign n_ext  = 32'(n_act);
    assign a_ext  = 32'(i_vertex_a);
    assign b_ext  = 32'(i_vertex_b);
    assign edge_ok = (a_ext >= 32'd1) && (a_ext <= n_ext)
                  && (b_ext >= 32'd1) && (b_ext <= n_ext);

    // Columns of vertices in use
    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            act_mask[i] = (32'(i) < n_ext);
        end
    end

    // Unvisited neighbors of the row just read
    assign row_new = adj_rdata & ~r_visited & act_mask;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_u       = r_u;
        n_tally   = r_tally;
        n_sp      = r_sp;
        n_visited = r_visited;
        n_cand    = r_cand;
        n_w       = r_w;
        n_row_a   = r_row_a;
        n_row_b   = r_row_b;
        adj_we    = 1'b0;
        adj_waddr = r_row_a;
        adj_wdata = '0;
        adj_raddr = r_row_a;
        stk_we    = 1'b0;
        stk_waddr = r_sp[AW-1:0];
        stk_wdata = r_w;
        stk_raddr = r_sp[AW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                adj_we    = 1'b1;
                adj_waddr = r_clr_idx;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == AW'(MAX_VERTICES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_command)
                        CMD_ADD_EDGE: begin
                            if (edge_ok) begin
                                n_row_a   = AW'(a_ext - 32'd1);
                                n_row_b   = AW'(b_ext - 32'd1);
                                adj_raddr = AW'(a_ext - 32'd1);
                                n_state   = S_ADD_A;
                            end
                        end
                        CMD_COUNT: begin
                            n_visited = '0;
                            n_tally   = '0;
                            n_u       = '0;
                            n_state   = S_SCAN;
                        end
                        CMD_CLEAR: begin
                            n_clr_idx = '0;
                            n_state   = S_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Row a is out: set bit b, fetch row b
            S_ADD_A: begin
                adj_we    = 1'b1;
                adj_waddr = r_row_a;
                adj_wdata = adj_rdata | (MAX_VERTICES'(1) << r_row_b);
                adj_raddr = r_row_b;
                n_state   = S_ADD_B;
            end
            S_ADD_B: begin
                adj_we    = 1'b1;
                adj_waddr = r_row_b;
                adj_wdata = adj_rdata | (MAX_VERTICES'(1) << r_row_a);
                n_state   = S_IDLE;
            end
            // Find the next unvisited start vertex
            S_SCAN: begin
                if (r_u == n_act) begin
                    n_state = S_DONE;
                end else if (r_visited[r_u[AW-1:0]]) begin
                    n_u = r_u + 1'b1;
                end else begin
                    n_tally                 = r_tally + 1'b1;
                    n_visited[r_u[AW-1:0]]  = 1'b1;
                    adj_raddr               = r_u[AW-1:0];
                    n_sp                    = '0;
                    n_u                     = r_u + 1'b1;
                    n_state                 = S_ROW;
                end
            end
            // Mark all new neighbors at once, then step through them and push each onto the stack
            S_ROW: begin
                n_cand    = row_new;
                n_visited = r_visited | row_new;
                n_w       = '0;
                n_state   = S_PUSH;
            end
            S_PUSH: begin
                if (r_cand == '0) begin
                    if (r_sp == '0) begin
                        n_state = S_SCAN;
                    end else begin
                        stk_raddr = AW'(r_sp - 1'b1);
                        n_sp      = r_sp - 1'b1;
                        n_state   = S_POP;
                    end
                end else begin
                    if (r_cand[0]) begin
                        stk_we    = 1'b1;
                        stk_waddr = r_sp[AW-1:0];
                        stk_wdata = r_w;
                        n_sp      = r_sp + 1'b1;
                    end
                    n_cand = r_cand >> 1;
                    n_w    = r_w + 1'b1;
                end
            end
            // Popped vertex is out: fetch its row
            S_POP: begin
                adj_raddr = stk_rdata;
                n_state   = S_ROW;
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_u       <= '0;
            r_tally   <= '0;
            r_sp      <= '0;
            r_visited <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_u       <= n_u;
            r_tally   <= n_tally;
            r_sp      <= n_sp;
            r_visited <= n_visited;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand  <= n_cand;
        r_w     <= n_w;
        r_row_a <= n_row_a;
        r_row_b <= n_row_b;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result.valid = (r_state == S_DONE);
    assign o_result.count = r_tally;

    `CCC_NEVER(a_stack_overflow, i_clk, i_rst_n, (r_state == S_PUSH) && (r_cand != '0) && r_cand[0] && (32'(r_sp) >= 32'(MAX_VERTICES)), "stack push while full")
    `CCC_ASSERT(a_cand_marked, i_clk, i_rst_n, (r_state == S_PUSH) |-> (((r_cand << r_w) & ~r_visited) == '0), "pending vertex not marked visited")
    `CCC_ASSERT(a_tally_bound, i_clk, i_rst_n, (r_state == S_DONE) |-> (32'(r_tally) <= n_ext), "component tally above vertex count")
    `CCC_ASSERT(a_scan_bound, i_clk, i_rst_n, (r_state == S_SCAN) |-> (32'(r_u) <= n_ext), "scan index past vertex count")

endmodule

// ===== rtl/core/connected_component_counter_unit.sv =====
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------
// in       | input     | i_in_valid / o_in_stall  | i_command, i_vertex_a, i_vertex_b
// out      | output    | o_out_valid / i_out_stall| o_component_count
// config   | input     | APB psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// Add edge is a read-modify-write of two adjacency rows; an ignored edge or an unused
// command changes nothing. Clear writes one row per cycle.
// Count walks each component depth first: each row read marks all new neighbors at once,
// then the candidate columns are stepped through and each new neighbor is pushed.
// Its pace is set by the adjacency RAM read port and the one-push-per-cycle stack port.
// After reset the adjacency RAM is cleared with o_in_stall high.
// A finished count waits in the output register; new transactions are taken meanwhile,
// but a following count completes only once that register is free.
module connected_component_counter_unit #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ccc_pkg::CMD_W-1:0]      i_command,
    input  logic [ccc_pkg::VTX_W-1:0]      i_vertex_a,
    input  logic [ccc_pkg::VTX_W-1:0]      i_vertex_b,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ccc_pkg::CNT_W-1:0]      o_component_count,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ccc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ccc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ccc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ccc_pkg::*;

    logic [VTX_W-1:0] vertex_count;
    logic             busy;
    logic             res_free;
    t_result          result;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;

    ccc_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_vertex_count (vertex_count)
    );

    ccc_walk #(.MAX_VERTICES(MAX_VERTICES)) u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_count (vertex_count),
        .i_cmd_valid    (i_in_valid && !busy),
        .i_command      (i_command),
        .i_vertex_a     (i_vertex_a),
        .i_vertex_b     (i_vertex_b),
        .i_res_free     (res_free),
        .o_busy         (busy),
        .o_result       (result)
    );

    // Output register: free when empty or its transaction completes now
    assign res_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid && res_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid && res_free) begin
            r_count <= result.count;
        end
    end

    assign o_in_stall        = busy;
    assign o_out_valid       = r_out_valid;
    assign o_component_count = r_count;

endmodule

// ===== tb/connected_component_counter_unit_test.sv =====
`timescale 1ns / 1ps

module connected_component_counter_unit_test;
    import ccc_pkg::*;

    localparam int MAX_VERTICES = 64;
    localparam int CYCLE_LIMIT  = 20_000_000;
    // clear pass plus margin; adds and clears return nothing, so wait them out
    localparam int SETTLE_CYCLES = 2 * MAX_VERTICES + 16;
    // longest count walk, used once at the end
    localparam int DRAIN_CYCLES  = MAX_VERTICES * (MAX_VERTICES + 4) + 100;
    localparam int RANDOM_ITEMS  = 900;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] VERTEX_COUNT_ADDR = CFG_ADDR_W'({REG_VERTEX_COUNT, 2'b00});
    localparam logic [CFG_ADDR_W-1:0] SPARE_REG_ADDR    = CFG_ADDR_W'(4);

    typedef logic [CMD_W-1:0] t_command;
    typedef logic [VTX_W-1:0] t_vertex;
    typedef logic [CNT_W-1:0] t_count;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_command              i_command;
    t_vertex               i_vertex_a;
    t_vertex               i_vertex_b;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_count                o_component_count;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Graph state mirrored by the testbench
    logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
    t_vertex                 vertex_limit;
    t_count                  pending_counts [$];

    int  failures = 0;
    int  cycle_count = 0;
    bit  in_idle_on = 1'b1;
    bit  out_idle_on = 1'b1;
    int  result_hold_cycles = 0;

    connected_component_counter_unit #(
        .MAX_VERTICES(MAX_VERTICES)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_command(i_command),
        .i_vertex_a(i_vertex_a),
        .i_vertex_b(i_vertex_b),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_component_count(o_component_count),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int active_vertices();
        return (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_limit);
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < MAX_VERTICES; i++) adj_rows[i] = '0;
    endfunction

    // Depth-first walk from each unreached vertex; one search per component
    function automatic t_count count_components(input int n);
        logic [MAX_VERTICES-1:0] reached;
        int dfs_stack [$];
        int tally;
        int u;
        reached = '0;
        tally = 0;
        for (int v = 0; v < n; v++) begin
            if (!reached[v]) begin
                tally++;
                reached[v] = 1'b1;
                dfs_stack.push_back(v);
                while (dfs_stack.size() > 0) begin
                    u = dfs_stack.pop_back();
                    for (int w = 0; w < n; w++) begin
                        if (adj_rows[u][w] && !reached[w]) begin
                            reached[w] = 1'b1;
                            dfs_stack.push_back(w);
                        end
                    end
                end
            end
        end
        return CNT_W'(tally);
    endfunction

    // Update the mirrored graph for one accepted transaction
    function automatic void apply_graph_command(input t_command cmd, input t_vertex a,
                                                input t_vertex b);
        int n;
        n = active_vertices();
        case (cmd)
            CMD_ADD_EDGE: begin
                if (a >= 1 && a <= n && b >= 1 && b <= n) begin
                    adj_rows[a - 1][b - 1] = 1'b1;
                    adj_rows[b - 1][a - 1] = 1'b1;
                end
            end
            CMD_COUNT: pending_counts.push_back(count_components(n));
            CMD_CLEAR: clear_graph();
            default: ;
        endcase
    endfunction

    function automatic void record_failure(input string msg);
        failures++;
        if (failures <= 10) $display("ERROR: %s", msg);
    endfunction

    function automatic void check_component_count(input t_count actual);
        t_count expected;
        if (pending_counts.size() == 0) begin
            record_failure($sformatf("component count %0d with none expected", actual));
        end else begin
            expected = pending_counts.pop_front();
            if (actual !== expected)
                record_failure($sformatf("component_count expected %0d actual %0d",
                                         expected, actual));
        end
    endfunction

    // Send one transaction; valid stays high afterwards until the next send or a drain
    task automatic send_item(input t_command cmd, input t_vertex a, input t_vertex b);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_vertex_a <= a;
        i_vertex_b <= b;
        do @(posedge i_clk); while (o_in_stall);
        apply_graph_command(cmd, a, b);
    endtask

    // Stop sending and wait until every count has come back and the block is quiet
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr, input t_vertex value);
        logic [31:0] noise;
        noise = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {noise[31:VTX_W], value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == VERTEX_COUNT_ADDR) vertex_limit = value;
    endtask

    task automatic set_vertex_count(input t_vertex value);
        wait_drain();
        write_register(VERTEX_COUNT_ADDR, value);
    endtask

    // Edge loads at the full vertex count: extremes, ignored endpoints, self-loop, repeats, unused command, clear
    task automatic test_edge_extremes();
        set_vertex_count(7'd64);
        send_item(CMD_COUNT, 7'd0, 7'd0);
        send_item(CMD_ADD_EDGE, 7'd1, 7'd64);
        send_item(CMD_ADD_EDGE, 7'd64, 7'd1);
        send_item(CMD_ADD_EDGE, 7'd5, 7'd5);
        send_item(CMD_ADD_EDGE, 7'd0, 7'd3);
        send_item(CMD_ADD_EDGE, 7'd3, 7'd0);
        send_item(CMD_ADD_EDGE, 7'd65, 7'd2);
        send_item(CMD_ADD_EDGE, 7'd127, 7'd127);
        send_item(CMD_UNUSED, 7'd127, 7'd127);
        send_item(CMD_ADD_EDGE, 7'd2, 7'd3);
        send_item(CMD_ADD_EDGE, 7'd64, 7'd64);
        send_item(CMD_COUNT, 7'd127, 7'd127);
        send_item(CMD_CLEAR, 7'd0, 7'd0);
        send_item(CMD_COUNT, 7'd0, 7'd0);
    endtask

    // Vertex count register: zero, one, above the maximum, spare address, lowered count
    task automatic test_vertex_count_register();
        set_vertex_count(7'd0);
        send_item(CMD_ADD_EDGE, 7'd1, 7'd1);
        send_item(CMD_COUNT, 7'd0, 7'd0);
        set_vertex_count(7'd1);
        send_item(CMD_COUNT, 7'd0, 7'd0);
        set_vertex_count(7'd127);
        send_item(CMD_ADD_EDGE, 7'd64, 7'd63);
        send_item(CMD_COUNT, 7'd0, 7'd0);
        wait_drain();
        write_register(SPARE_REG_ADDR, 7'd5);
        send_item(CMD_COUNT, 7'd0, 7'd0);
        set_vertex_count(7'd64);
        send_item(CMD_ADD_EDGE, 7'd10, 7'd40);
        send_item(CMD_ADD_EDGE, 7'd3, 7'd50);
        send_item(CMD_ADD_EDGE, 7'd3, 7'd4);
        set_vertex_count(7'd20);
        send_item(CMD_COUNT, 7'd0, 7'd0);
        set_vertex_count(7'd100);
        send_item(CMD_COUNT, 7'd0, 7'd0);
    endtask

    // Receiver holds off long enough that finished counts back up into the input
    task automatic test_output_backpressure();
        set_vertex_count(7'd8);
        in_idle_on = 1'b0;
        result_hold_cycles = 400;
        for (int i = 0; i < 16; i++) begin
            if (i % 3 == 0)
                send_item(CMD_COUNT, 7'd0, 7'd0);
            else
                send_item(CMD_ADD_EDGE, t_vertex'($urandom_range(1, 8)),
                          t_vertex'($urandom_range(1, 8)));
        end
        wait_drain();
        in_idle_on = 1'b1;
    endtask

    // Mostly well-formed loads and counts, with some noise mixed in
    task automatic send_random_item(input int n);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            send_item(CMD_ADD_EDGE, t_vertex'($urandom_range(1, n)),
                      t_vertex'($urandom_range(1, n)));
        else if (pick < 80)
            send_item(CMD_COUNT, t_vertex'($urandom_range(0, 127)),
                      t_vertex'($urandom_range(0, 127)));
        else if (pick < 84)
            send_item(CMD_CLEAR, t_vertex'($urandom_range(0, 127)),
                      t_vertex'($urandom_range(0, 127)));
        else if (pick < 93)
            send_item(CMD_ADD_EDGE, t_vertex'($urandom_range(0, 127)),
                      t_vertex'($urandom_range(0, 127)));
        else
            send_item(CMD_UNUSED, t_vertex'($urandom_range(0, 127)),
                      t_vertex'($urandom_range(0, 127)));
    endtask

    // Random graphs in phases; small vertex counts keep the walks short
    task automatic test_random_graphs();
        int sent;
        int pick;
        int n;
        int phase_items;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       n = 64;
            else if (pick < 12) n = 1;
            else if (pick < 15) n = $urandom_range(65, 127);
            else                n = $urandom_range(2, 16);
            set_vertex_count(t_vertex'(n));
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            if (n > MAX_VERTICES) n = MAX_VERTICES;
            if ($urandom_range(0, 1)) begin
                send_item(CMD_CLEAR, 7'd0, 7'd0);
                sent++;
            end
            phase_items = (n > 16) ? 15 : $urandom_range(30, 60);
            repeat (phase_items) begin
                send_random_item(n);
                sent++;
            end
            send_item(CMD_COUNT, 7'd0, 7'd0);
            sent++;
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // Result side: random stalls, optional long hold-off, check every transaction
    initial begin : result_receiver
        int wait_cycles;
        forever begin
            if (result_hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (result_hold_cycles) @(posedge i_clk);
                result_hold_cycles = 0;
            end
            wait_cycles = out_idle_on ? $urandom_range(0, 8) : 0;
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid));
            check_component_count(o_component_count);
        end
    end

    // Sequence of tests
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_command  = CMD_ADD_EDGE;
        i_vertex_a = '0;
        i_vertex_b = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        clear_graph();
        vertex_limit = VERTEX_COUNT_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // startup clear of the adjacency store
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        test_edge_extremes();
        test_vertex_count_register();
        test_output_backpressure();
        test_random_graphs();

        out_idle_on = 1'b0;
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending_counts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ccc_pkg.sv
rtl/core/ccc_ram.sv
rtl/core/ccc_cfg.sv
rtl/core/ccc_walk.sv
rtl/core/connected_component_counter_unit.sv
tb/connected_component_counter_unit_test.sv
